[rtl/core/ppg_pkg.sv]
// Package: shared types and constants for the pan/press gesture core.
`default_nettype none
package ppg_pkg;
	localparam int COORD_BITS  = 20;
	localparam int TARGET_BITS = 32;
	localparam int DELTA_BITS  = COORD_BITS + 1;
	localparam int VEL_BITS    = 31;
	localparam int EL_BITS     = 31;
	// delta * 1e6 fits in DELTA_BITS + 20 bits signed
	localparam int NUM_BITS    = DELTA_BITS + 20;
	localparam int QCNT_BITS   = $clog2(NUM_BITS + 1);
	localparam int ADDR_BITS   = 4;
	localparam logic [30:0] MIN_ELAPSED = 31'd1000;
	localparam logic [19:0] SCALE_1E6   = 20'd1000000;

	typedef enum logic [1:0] {OP_PAN = 2'd0, OP_PRESS = 2'd1, OP_CANCEL = 2'd2,
		OP_NONE = 2'd3} op_t;
	typedef enum logic [1:0] {KIND_NONE = 2'd0, KIND_PAN = 2'd1, KIND_PRESS = 2'd2}
		gkind_t;
	typedef enum logic [2:0] {
		EV_PAN_START = 3'd0, EV_PAN_UPDATE = 3'd1, EV_PAN_END = 3'd2,
		EV_PRESS_START = 3'd3, EV_PRESS_MOVE = 3'd4, EV_PRESS_RELEASE = 3'd5,
		EV_PRESS_CANCEL = 3'd6, EV_CANCEL = 3'd7} ev_t;
	typedef enum logic [3:0] {
		ADDR_PAN_EN = 4'd0, ADDR_PRESS_EN = 4'd4, ADDR_THRESH = 4'd8,
		ADDR_IMMED = 4'd12} addr_t;
	typedef enum logic [2:0] {
		ST_IDLE, ST_DECIDE, ST_SQUARE, ST_THRESH, ST_PREP, ST_DIV, ST_OUT} state_t;

	typedef struct packed {
		logic [1:0]             operation;
		logic [COORD_BITS-1:0]  pointer_x;
		logic [COORD_BITS-1:0]  pointer_y;
		logic [31:0]            pointer_time;
		logic                   pressed;
		logic                   down;
		logic                   released;
		logic [TARGET_BITS-1:0] target;
		logic                   hit;
		logic                   bounds_given;
		logic [COORD_BITS-1:0]  org_x;
		logic [COORD_BITS-1:0]  org_y;
	} req_t;

	typedef struct packed {
		logic [2:0]             event_kind;
		logic [TARGET_BITS-1:0] event_target;
		logic [DELTA_BITS-1:0]  delta_x;
		logic [DELTA_BITS-1:0]  delta_y;
		logic [DELTA_BITS-1:0]  step_dx;
		logic [DELTA_BITS-1:0]  step_dy;
		logic                   local_valid;
		logic [DELTA_BITS-1:0]  local_x;
		logic [DELTA_BITS-1:0]  local_y;
		logic [EL_BITS-1:0]     elapsed_us;
		logic [VEL_BITS-1:0]    speed_x;
		logic [VEL_BITS-1:0]    speed_y;
	} rsp_t;

	// decision made by the controller from the datapath status
	typedef enum logic [2:0] {
		ACT_NONE, ACT_CLEAR, ACT_CANCEL, ACT_START, ACT_END, ACT_CHECK, ACT_MOVE
	} act_t;

	typedef struct packed {
		logic   load_req;   // capture input request
		logic   apply;      // commit state update for act
		act_t   act;
		logic   emit;       // act produces a result
		logic [2:0] ev;
		logic   sq_go;      // register squares
		logic   prep;       // build event fields, load divider
		logic   div_step;
		logic   out_load;
	} cmd_t;

	typedef struct packed {
		logic   active;
		logic   accepted;
		logic [1:0] kind;
		logic   tgt_match;
		logic   same_point;
		logic   past_thresh;
		logic   div_done;
	} sts_t;
endpackage
`default_nettype wire

[rtl/core/ppg_if.sv]
// Interfaces: request and result channels.
`default_nettype none
interface ppg_req_if import ppg_pkg::*; ();
	logic valid;
	logic ready;
	req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface ppg_rsp_if import ppg_pkg::*; ();
	logic valid;
	logic ready;
	rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

[rtl/core/ppg_ctrl.sv]
// Controller state machine: sequences one request through decide, slop check and divide.
`default_nettype none
module ppg_ctrl import ppg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	output logic      in_ready,
	input  wire logic [1:0] op,
	input  wire logic pressed,
	input  wire logic down,
	input  wire logic released,
	input  wire logic tgt_zero,
	input  wire logic hit,
	input  wire logic pan_en,
	input  wire logic press_en,
	input  wire logic immed,
	input  wire logic thresh_zero,
	input  wire logic out_busy,
	input  sts_t      sts,
	output cmd_t      cmd
);
	state_t state_q, state_d;
	logic [1:0] op_q;
	logic pr_q, dn_q, rl_q, tz_q, hit_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			op_q <= op; pr_q <= pressed; dn_q <= down; rl_q <= released;
			tz_q <= tgt_zero; hit_q <= hit;
		end
	end

	// decision logic, evaluated in ST_DECIDE
	logic is_pan, en;
	act_t act;
	logic emit;
	logic [2:0] ev;
	always_comb begin
		is_pan = (op_q == OP_PAN);
		en = is_pan ? pan_en : press_en;
		act = ACT_NONE; emit = 1'b0; ev = EV_CANCEL;
		if (op_q == OP_CANCEL) begin
			if (sts.active) begin
				act = ACT_CANCEL; emit = sts.accepted;
				ev = (sts.kind == KIND_PRESS) ? EV_PRESS_CANCEL : EV_CANCEL;
			end
		end else if (op_q == OP_NONE) begin
			act = ACT_NONE;
		end else if (sts.active && (!en || tz_q || !sts.tgt_match ||
				sts.kind != (is_pan ? KIND_PAN : KIND_PRESS))) begin
			act = ACT_CANCEL; emit = sts.accepted;
			ev = (sts.kind == KIND_PRESS) ? EV_PRESS_CANCEL : EV_CANCEL;
		end else if (!sts.active) begin
			if (en && !tz_q && hit_q && pr_q && dn_q) begin
				act = ACT_START;
				emit = !is_pan || immed || thresh_zero;
				ev = is_pan ? EV_PAN_START : EV_PRESS_START;
			end
		end else if (!dn_q || rl_q) begin
			act = sts.accepted ? ACT_END : ACT_CLEAR;
			emit = sts.accepted;
			ev = is_pan ? EV_PAN_END : EV_PRESS_RELEASE;
		end else if (!sts.accepted) begin
			act = ACT_CHECK; emit = 1'b0; ev = EV_PAN_START;
		end else if (!sts.same_point) begin
			act = ACT_MOVE; emit = 1'b1;
			ev = is_pan ? EV_PAN_UPDATE : EV_PRESS_MOVE;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE:   if (in_valid) state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (act == ACT_CHECK) state_d = ST_SQUARE;
				else if (emit) state_d = ST_PREP;
				else state_d = ST_IDLE;
			end
			ST_SQUARE: state_d = ST_THRESH;
			ST_THRESH: state_d = sts.past_thresh ? ST_PREP : ST_IDLE;
			ST_PREP:   state_d = ST_DIV;
			ST_DIV:    if (sts.div_done) state_d = ST_OUT;
			ST_OUT:    if (!out_busy) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	// act and event held from decide through the output stage
	act_t act_q;
	logic [2:0] ev_q;
	always_ff @(posedge clk) begin
		if (state_q == ST_DECIDE) begin
			act_q <= act; ev_q <= ev;
		end
	end

	always_comb begin
		cmd = '0;
		cmd.act = act;
		cmd.ev = ev;
		in_ready = (state_q == ST_IDLE);
		cmd.load_req = in_valid && in_ready;
		case (state_q)
			ST_DECIDE: begin
				// fields taken from pre-update slot state (a start uses the new values); slot update lands on the same edge
				cmd.prep = emit;
				cmd.apply = (act != ACT_CHECK);
				cmd.emit = emit;
				cmd.sq_go = (act == ACT_CHECK);
			end
			ST_SQUARE: ;
			ST_THRESH: begin
				cmd.act = ACT_CHECK; cmd.ev = ev_q;
				cmd.apply = 1'b1;
				cmd.prep = sts.past_thresh;
				cmd.emit = sts.past_thresh;
			end
			ST_DIV: begin
				cmd.act = act_q; cmd.ev = ev_q;
				cmd.div_step = 1'b1;
			end
			ST_OUT: begin
				cmd.act = act_q; cmd.ev = ev_q;
				cmd.out_load = !out_busy;
			end
			default: ;
		endcase
	end
endmodule
`default_nettype wire

[rtl/core/ppg_div.sv]
// Two signed restoring dividers sharing a divisor, one quotient bit per cycle each.
`default_nettype none
module ppg_div import ppg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic start,
	input  wire logic step,
	input  wire logic signed [NUM_BITS-1:0] num_x,
	input  wire logic signed [NUM_BITS-1:0] num_y,
	input  wire logic [EL_BITS-1:0] den,
	output logic done,
	output logic [VEL_BITS-1:0] vel_x,
	output logic [VEL_BITS-1:0] vel_y
);
	logic [QCNT_BITS-1:0] cnt_q;
	logic [NUM_BITS-1:0] qx_q, qy_q;
	logic [EL_BITS:0] rx_q, ry_q;
	logic [EL_BITS-1:0] den_q;
	logic nx_q, ny_q;

	logic [EL_BITS:0] rx_sh, ry_sh, rx_sub, ry_sub;
	always_comb begin
		rx_sh = {rx_q[EL_BITS-1:0], qx_q[NUM_BITS-1]};
		ry_sh = {ry_q[EL_BITS-1:0], qy_q[NUM_BITS-1]};
		rx_sub = rx_sh - {1'b0, den_q};
		ry_sub = ry_sh - {1'b0, den_q};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
		end else if (start) begin
			cnt_q <= QCNT_BITS'(NUM_BITS);
		end else if (step && cnt_q != '0) begin
			cnt_q <= cnt_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			nx_q <= num_x[NUM_BITS-1];
			ny_q <= num_y[NUM_BITS-1];
			qx_q <= num_x[NUM_BITS-1] ? NUM_BITS'(-num_x) : num_x;
			qy_q <= num_y[NUM_BITS-1] ? NUM_BITS'(-num_y) : num_y;
			rx_q <= '0; ry_q <= '0;
			den_q <= den;
		end else if (step && cnt_q != '0) begin
			rx_q <= rx_sub[EL_BITS] ? rx_sh : rx_sub;
			ry_q <= ry_sub[EL_BITS] ? ry_sh : ry_sub;
			qx_q <= {qx_q[NUM_BITS-2:0], ~rx_sub[EL_BITS]};
			qy_q <= {qy_q[NUM_BITS-2:0], ~ry_sub[EL_BITS]};
		end
	end

	assign done = (cnt_q == '0);

	localparam logic [NUM_BITS-1:0] VMAG = NUM_BITS'(1073741823);
	logic [NUM_BITS-1:0] mx, my;
	always_comb begin
		mx = (qx_q > VMAG) ? VMAG : qx_q;
		my = (qy_q > VMAG) ? VMAG : qy_q;
		// negative side may reach -2^30; magnitude 2^30 allowed only when negative
		if (nx_q) vel_x = (qx_q > VMAG) ? 31'h40000000 : VEL_BITS'(-mx);
		else      vel_x = VEL_BITS'(mx);
		if (ny_q) vel_y = (qy_q > VMAG) ? 31'h40000000 : VEL_BITS'(-my);
		else      vel_y = VEL_BITS'(my);
	end
endmodule
`default_nettype wire

[rtl/core/ppg_dp.sv]
// Datapath: gesture slot registers, event field arithmetic, slop check, divider and output stage.
`default_nettype none
module ppg_dp import ppg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  req_t      req,
	input  cmd_t      cmd,
	input  wire logic [15:0] thresh,
	input  wire logic immed,
	output sts_t      sts,
	output logic      out_busy,
	output logic      out_valid,
	input  wire logic out_ready,
	output rsp_t      out_data
);
	req_t r_q;
	logic active_q, accepted_q, local_q;
	gkind_t kind_q;
	logic [TARGET_BITS-1:0] tgt_q;
	logic signed [COORD_BITS-1:0] ox_q, oy_q, sx_q, sy_q, lx_q, ly_q;
	logic [31:0] st_q, lt_q;

	always_ff @(posedge clk) begin
		if (cmd.load_req) r_q <= req;
	end

	// event point: last point on cancel, else the request point
	logic is_cancel;
	logic signed [COORD_BITS-1:0] px, py;
	logic [31:0] pt;
	logic [1:0] op_k;
	always_comb begin
		is_cancel = (cmd.act == ACT_CANCEL);
		op_k = (r_q.operation == OP_PAN) ? KIND_PAN : KIND_PRESS;
		px = is_cancel ? lx_q : r_q.pointer_x;
		py = is_cancel ? ly_q : r_q.pointer_y;
		pt = is_cancel ? lt_q : r_q.pointer_time;
	end

	// on start the fields are computed against the new slot values
	logic start;
	logic signed [COORD_BITS-1:0] bsx, bsy, blx, bly, box, boy;
	logic [31:0] bst;
	logic bloc;
	logic [TARGET_BITS-1:0] btgt;
	always_comb begin
		start = (cmd.act == ACT_START);
		bsx = start ? r_q.pointer_x : sx_q;
		bsy = start ? r_q.pointer_y : sy_q;
		blx = start ? r_q.pointer_x : lx_q;
		bly = start ? r_q.pointer_y : ly_q;
		bst = start ? r_q.pointer_time : st_q;
		bloc = start ? (op_k == KIND_PRESS && r_q.bounds_given) : local_q;
		box = start ? ((op_k == KIND_PRESS && r_q.bounds_given) ? r_q.org_x : '0) : ox_q;
		boy = start ? ((op_k == KIND_PRESS && r_q.bounds_given) ? r_q.org_y : '0) : oy_q;
		btgt = start ? r_q.target : tgt_q;
	end

	logic signed [DELTA_BITS-1:0] dx, dy;
	logic signed [32:0] el_raw;
	logic [EL_BITS-1:0] el;
	always_comb begin
		dx = DELTA_BITS'(px) - DELTA_BITS'(bsx);
		dy = DELTA_BITS'(py) - DELTA_BITS'(bsy);
		el_raw = $signed({1'b0, pt}) - $signed({1'b0, bst});
		if (el_raw < 33'sd1000) el = MIN_ELAPSED;
		else if (el_raw > 33'sd2147483647) el = '1;
		else el = el_raw[EL_BITS-1:0];
	end

	// prep stage: register fields and the delta products
	rsp_t f_s1;
	logic signed [NUM_BITS-1:0] nx_s1, ny_s1;
	always_ff @(posedge clk) begin
		if (cmd.prep) begin
			f_s1.event_kind <= cmd.ev;
			f_s1.event_target <= btgt;
			f_s1.delta_x <= dx;
			f_s1.delta_y <= dy;
			f_s1.step_dx <= DELTA_BITS'(px) - DELTA_BITS'(blx);
			f_s1.step_dy <= DELTA_BITS'(py) - DELTA_BITS'(bly);
			f_s1.local_valid <= bloc;
			f_s1.local_x <= DELTA_BITS'(px) - DELTA_BITS'(box);
			f_s1.local_y <= DELTA_BITS'(py) - DELTA_BITS'(boy);
			f_s1.elapsed_us <= el;
			f_s1.speed_x <= '0;
			f_s1.speed_y <= '0;
			nx_s1 <= NUM_BITS'(dx) * $signed({1'b0, SCALE_1E6});
			ny_s1 <= NUM_BITS'(dy) * $signed({1'b0, SCALE_1E6});
		end
	end

	logic div_start_q;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) div_start_q <= 1'b0;
		else div_start_q <= cmd.prep;
	end

	logic div_done;
	logic [VEL_BITS-1:0] vx, vy;
	ppg_div u_div (
		.clk, .arst_n,
		.start(div_start_q),
		.step(cmd.div_step && !div_start_q),
		.num_x(nx_s1), .num_y(ny_s1),
		.den(f_s1.elapsed_us),
		.done(div_done),
		.vel_x(vx), .vel_y(vy)
	);

	// slop check: squares registered from ST_DECIDE, compared in ST_THRESH
	logic [DELTA_BITS-1:0] ax, ay;
	logic big_q;
	logic [31:0] sqx_q, sqy_q;
	always_comb begin
		ax = dx[DELTA_BITS-1] ? DELTA_BITS'(-dx) : dx;
		ay = dy[DELTA_BITS-1] ? DELTA_BITS'(-dy) : dy;
	end
	always_ff @(posedge clk) begin
		if (cmd.sq_go) begin
			big_q <= (ax > DELTA_BITS'(16'hFFFF)) || (ay > DELTA_BITS'(16'hFFFF));
			sqx_q <= ax[15:0] * ax[15:0];
			sqy_q <= ay[15:0] * ay[15:0];
		end
	end
	logic [32:0] sum;
	logic [31:0] th2;
	always_comb begin
		sum = {1'b0, sqx_q} + {1'b0, sqy_q};
		th2 = thresh * thresh;
	end

	// slot update
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			active_q <= 1'b0; accepted_q <= 1'b0; kind_q <= KIND_NONE;
			tgt_q <= '0; local_q <= 1'b0;
			ox_q <= '0; oy_q <= '0; sx_q <= '0; sy_q <= '0;
			lx_q <= '0; ly_q <= '0; st_q <= '0; lt_q <= '0;
		end else if (cmd.apply) begin
			case (cmd.act)
				ACT_CLEAR, ACT_CANCEL, ACT_END: begin
					active_q <= 1'b0; accepted_q <= 1'b0; kind_q <= KIND_NONE;
					tgt_q <= '0; local_q <= 1'b0;
					ox_q <= '0; oy_q <= '0; sx_q <= '0; sy_q <= '0;
					lx_q <= '0; ly_q <= '0; st_q <= '0; lt_q <= '0;
				end
				ACT_START: begin
					active_q <= 1'b1;
					accepted_q <= (op_k == KIND_PRESS) || immed || (thresh == '0);
					kind_q <= gkind_t'(op_k);
					tgt_q <= r_q.target; local_q <= bloc;
					ox_q <= box; oy_q <= boy;
					sx_q <= r_q.pointer_x; sy_q <= r_q.pointer_y;
					lx_q <= r_q.pointer_x; ly_q <= r_q.pointer_y;
					st_q <= r_q.pointer_time; lt_q <= r_q.pointer_time;
				end
				ACT_CHECK, ACT_MOVE: begin
					if (cmd.act == ACT_CHECK && sts.past_thresh) accepted_q <= 1'b1;
					lx_q <= r_q.pointer_x; ly_q <= r_q.pointer_y;
					lt_q <= r_q.pointer_time;
				end
				default: ;
			endcase
		end
	end

	always_comb begin
		sts.active = active_q;
		sts.accepted = accepted_q;
		sts.kind = kind_q;
		sts.tgt_match = (r_q.target == tgt_q);
		sts.same_point = (r_q.pointer_x == lx_q) && (r_q.pointer_y == ly_q);
		sts.past_thresh = big_q || (sum >= {1'b0, th2});
		sts.div_done = div_done && !div_start_q;
	end

	// output register
	rsp_t f_out;
	always_comb begin
		f_out = f_s1;
		f_out.speed_x = vx;
		f_out.speed_y = vy;
	end
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid <= 1'b0;
		else if (cmd.out_load) out_valid <= 1'b1;
		else if (out_ready) out_valid <= 1'b0;
	end
	always_ff @(posedge clk) begin
		if (cmd.out_load) out_data <= f_out;
	end
	assign out_busy = out_valid && !out_ready;
endmodule
`default_nettype wire

[rtl/core/pan_press_gesture_recognizer_core.sv]
// Top level: pan/press gesture recognizer with touch slop.
//
//  channel  | dir | type              | payload
//  req      | in  | ppg_req_if.sink   | operation, pointer, time, buttons, target, origin
//  rsp      | out | ppg_rsp_if.source | event kind, target, deltas, local, elapsed, velocity
//  apb      | in  | psel/penable/...  | pan_enabled, press_enabled, pan_threshold, immediate
//
// One request at a time. A request with no result goes through decide (and the
// square and threshold steps of the slop check); one with a result also goes through
// prep, the bit-serial velocity divider over a 41-bit dividend, and the output stage.
// arst_n clears the slot and the registers (threshold to 96).
// A result waiting at the output stalls only the final transfer step.
`default_nettype none
module pan_press_gesture_recognizer_core import ppg_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	ppg_req_if.sink   req,
	ppg_rsp_if.source rsp,
	input  wire logic psel,
	input  wire logic penable,
	input  wire logic pwrite,
	input  wire logic [ADDR_BITS-1:0] paddr,
	input  wire logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic pready
);
	logic pan_en_q, press_en_q, immed_q;
	logic [15:0] thresh_q;

	assign pready = 1'b1;
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pan_en_q <= 1'b0; press_en_q <= 1'b0;
			thresh_q <= 16'd96; immed_q <= 1'b0;
		end else if (psel && penable && pwrite) begin
			case (paddr)
				ADDR_PAN_EN:   pan_en_q <= pwdata[0];
				ADDR_PRESS_EN: press_en_q <= pwdata[0];
				ADDR_THRESH:   thresh_q <= pwdata[15:0];
				ADDR_IMMED:    immed_q <= pwdata[0];
				default: ;
			endcase
		end
	end
	always_comb begin
		case (paddr)
			ADDR_PAN_EN:   prdata = {31'd0, pan_en_q};
			ADDR_PRESS_EN: prdata = {31'd0, press_en_q};
			ADDR_THRESH:   prdata = {16'd0, thresh_q};
			ADDR_IMMED:    prdata = {31'd0, immed_q};
			default:       prdata = '0;
		endcase
	end

	cmd_t cmd;
	sts_t sts;
	logic out_busy;

	// thresh_zero only matters for a pan start
	ppg_ctrl u_ctrl (
		.clk, .arst_n,
		.in_valid(req.valid), .in_ready(req.ready),
		.op(req.data.operation),
		.pressed(req.data.pressed), .down(req.data.down),
		.released(req.data.released),
		.tgt_zero(req.data.target == '0), .hit(req.data.hit),
		.pan_en(pan_en_q), .press_en(press_en_q), .immed(immed_q),
		.thresh_zero(thresh_q == '0),
		.out_busy, .sts, .cmd
	);

	ppg_dp u_dp (
		.clk, .arst_n,
		.req(req.data), .cmd, .thresh(thresh_q), .immed(immed_q),
		.sts, .out_busy,
		.out_valid(rsp.valid), .out_ready(rsp.ready), .out_data(rsp.data)
	);
endmodule
`default_nettype wire

[rtl/core/ppg_chk.sv]
// Port checker for the gesture core, bound to the top level.
`default_nettype none
module ppg_chk import ppg_pkg::*; (
	input wire logic clk,
	input wire logic arst_n,
	input wire logic req_valid,
	input wire logic req_ready,
	input wire logic rsp_valid,
	input wire logic rsp_ready,
	input wire logic [30:0] elapsed_us,
	input wire logic [2:0] event_kind
);
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> rsp_valid) else $error("result dropped");
	a_min_el: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid |-> elapsed_us >= MIN_ELAPSED) else $error("elapsed below floor");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		req_valid && req_ready |=> !req_ready) else $error("request overlap");
	a_kind: assert property (@(posedge clk) disable iff (!arst_n)
		rsp_valid && !rsp_ready |=> $stable(event_kind)) else $error("kind changed");
endmodule

bind pan_press_gesture_recognizer_core ppg_chk u_chk (
	.clk, .arst_n,
	.req_valid(req.valid), .req_ready(req.ready),
	.rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
	.elapsed_us(rsp.data.elapsed_us), .event_kind(rsp.data.event_kind)
);
`default_nettype wire
